FILE: hw/rtl/integer_remainder_unit_top_defines.svh
// assertion macros for the remainder unit
`ifndef INTEGER_REMAINDER_UNIT_TOP_DEFINES_SVH
`define INTEGER_REMAINDER_UNIT_TOP_DEFINES_SVH

// implication checked every clock outside reset
`define IRU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define IRU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/iru_pkg.sv
package iru_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned DivW   = 32;
  localparam int unsigned NumStg = 64;
  // restoring steps per pipeline stage
  localparam int unsigned BitsPerStg = 4;
  localparam int unsigned NumDivStg  = NumStg / BitsPerStg;

  typedef enum logic [1:0] {
    FUNC_S32 = 2'd0,
    FUNC_S64 = 2'd1,
    FUNC_U32 = 2'd2,
    FUNC_U64 = 2'd3
  } func_e;

  typedef struct packed {
    logic [DataW-1:0] dividend;
    logic [1:0]       func;
    logic [DivW-1:0]  divisor;
  } iru_req_t;

  typedef struct packed {
    logic [DataW-1:0] remainder;
    logic             div_by_zero;
  } iru_rsp_t;

  // per-item control traveling down the pipe
  typedef struct packed {
    logic             neg_res;
    logic             zero;
    logic             wide;
    logic             sgn;
    logic [DataW-1:0] raw;
  } iru_ctl_t;

endpackage

FILE: hw/rtl/iru_if.sv
interface iru_req_if;
  import iru_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [DataW-1:0] dividend;
  logic [DivW-1:0]  divisor;
  modport source (output valid, func, dividend, divisor, input ready);
  modport sink (input valid, func, dividend, divisor, output ready);
endinterface

interface iru_rsp_if;
  import iru_pkg::*;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] remainder;
  logic             div_by_zero;
  modport source (output valid, remainder, div_by_zero, input ready);
  modport sink (input valid, remainder, div_by_zero, output ready);
endinterface

FILE: hw/rtl/iru_div_stage.sv
// four restoring remainder steps, one register stage
module iru_div_stage import iru_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DataW-1:0] rem_i,
  input  logic [DataW-1:0] quo_i,
  input  logic [DataW-1:0] den_i,
  input  iru_ctl_t         ctl_i,
  output logic             valid_o,
  output logic [DataW-1:0] rem_o,
  output logic [DataW-1:0] quo_o,
  output logic [DataW-1:0] den_o,
  output iru_ctl_t         ctl_o
);

  logic [DataW-1:0] rem_d, quo_d, rem_q, quo_q, den_q;
  logic [DataW:0]   trial;
  iru_ctl_t         ctl_q;
  logic             valid_q;

  // quo holds the dividend bits not yet shifted in; each step moves its top bit into the remainder
  always_comb begin
    rem_d = rem_i;
    quo_d = quo_i;
    trial = '0;
    for (int i = 0; i < BitsPerStg; i++) begin
      trial = {rem_d, quo_d[DataW-1]} - {1'b0, den_i};
      quo_d = {quo_d[DataW-2:0], 1'b0};
      if (!trial[DataW]) begin
        rem_d = trial[DataW-1:0];
      end else begin
        rem_d = {rem_d[DataW-2:0], quo_i[DataW-1-i]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      den_q <= den_i;
      ctl_q <= ctl_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign den_o   = den_q;
  assign ctl_o   = ctl_q;

endmodule

FILE: hw/rtl/integer_remainder_unit_top.sv
// integer remainder unit, truncating division, four modes (func)
// req channel: func, dividend, divisor; rsp channel: remainder, div_by_zero
// a word is taken when valid and ready are both high on a channel
// stages from req accept to rsp valid: one operand stage,
// 16 divide stages of four restoring steps each, one fix-up stage
// throughput: one word per cycle while the rsp receiver does not stall; the 64-step shift-subtract chain is
// split over the 16 divide stages so each stage holds four steps
// the pipe advances as a whole: when the rsp receiver stalls and the
// output register is full, every stage holds and req.ready drops
// req.ready is high whenever the output register is empty or drained
// reset clears all valid bits; payload registers are not reset
// zero divisor returns the mode's dividend with div_by_zero set
// signed minimum over minus one yields zero with no flag
// 32-bit modes extend the result by the mode's signedness
module integer_remainder_unit_top import iru_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  iru_req_if.sink   req,
  iru_rsp_if.source rsp
);
`include "integer_remainder_unit_top_defines.svh"

  logic en;
  logic [DataW-1:0] v_ext, m_ext, v_mag, m_mag;
  logic wide, sgn, zero;
  iru_ctl_t ctl_d;

  logic             valid_s [NumDivStg+1];
  logic [DataW-1:0] rem_s   [NumDivStg+1];
  logic [DataW-1:0] quo_s   [NumDivStg+1];
  logic [DataW-1:0] den_s   [NumDivStg+1];
  iru_ctl_t         ctl_s   [NumDivStg+1];

  logic             in_valid_q, out_valid_q;
  logic [DataW-1:0] in_quo_q, in_den_q;
  iru_ctl_t         in_ctl_q;
  logic [DataW-1:0] res_d, res_q, fin;
  logic             dbz_q;

  assign en        = !out_valid_q || rsp.ready;
  assign req.ready = en;

  always_comb begin
    wide = req.func[0];
    sgn  = !req.func[1];
    zero = (req.divisor == '0);
    if (wide) begin
      v_ext = req.dividend;
    end else if (sgn) begin
      v_ext = {{(DataW-32){req.dividend[31]}}, req.dividend[31:0]};
    end else begin
      v_ext = {{(DataW-32){1'b0}}, req.dividend[31:0]};
    end
    if (!sgn && !wide) begin
      m_ext = {{(DataW-DivW){1'b0}}, req.divisor};
    end else begin
      m_ext = {{(DataW-DivW){req.divisor[DivW-1]}}, req.divisor};
    end
    v_mag = (sgn && v_ext[DataW-1]) ? (~v_ext + 1'b1) : v_ext;
    m_mag = (sgn && m_ext[DataW-1]) ? (~m_ext + 1'b1) : m_ext;
    ctl_d.neg_res = sgn && v_ext[DataW-1];
    ctl_d.zero    = zero;
    ctl_d.wide    = wide;
    ctl_d.sgn     = sgn;
    ctl_d.raw     = v_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_quo_q <= v_mag;
      // zero divisor: use one so the pipe stays benign
      in_den_q <= zero ? {{(DataW-1){1'b0}}, 1'b1} : m_mag;
      in_ctl_q <= ctl_d;
    end
  end

  assign valid_s[0] = in_valid_q;
  assign rem_s[0]   = '0;
  assign quo_s[0]   = in_quo_q;
  assign den_s[0]   = in_den_q;
  assign ctl_s[0]   = in_ctl_q;

  for (genvar g = 0; g < NumDivStg; g++) begin : g_stg
    iru_div_stage u_stg (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_s[g]),
      .rem_i   (rem_s[g]),
      .quo_i   (quo_s[g]),
      .den_i   (den_s[g]),
      .ctl_i   (ctl_s[g]),
      .valid_o (valid_s[g+1]),
      .rem_o   (rem_s[g+1]),
      .quo_o   (quo_s[g+1]),
      .den_o   (den_s[g+1]),
      .ctl_o   (ctl_s[g+1])
    );
  end

  always_comb begin
    fin = ctl_s[NumDivStg].neg_res ? (~rem_s[NumDivStg] + 1'b1) : rem_s[NumDivStg];
    if (ctl_s[NumDivStg].zero) begin
      res_d = ctl_s[NumDivStg].raw;
    end else if (ctl_s[NumDivStg].wide) begin
      res_d = fin;
    end else if (ctl_s[NumDivStg].sgn) begin
      res_d = {{(DataW-32){fin[31]}}, fin[31:0]};
    end else begin
      res_d = {{(DataW-32){1'b0}}, fin[31:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_s[NumDivStg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      dbz_q <= ctl_s[NumDivStg].zero;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.remainder   = res_q;
  assign rsp.div_by_zero = dbz_q;

  `IRU_ASSERT_NEXT(a_hold_out, out_valid_q && !rsp.ready, out_valid_q && $stable(res_q))
  `IRU_ASSERT_IMPL(a_ready_when_empty, !out_valid_q, req.ready)
  `IRU_ASSERT_NEXT(a_dbz_raw, en && ctl_s[NumDivStg].zero && valid_s[NumDivStg],
                   dbz_q && res_q == $past(ctl_s[NumDivStg].raw))

endmodule

FILE: sim/iru_tb_if.sv
`timescale 1ns / 100ps

// the block's own interfaces (iru_req_if, iru_rsp_if) are used for the channels;
// this file holds the word types shared by the checker and the top
package iru_tb_pkg;
  import iru_pkg::*;

  typedef struct packed {
    func_e            func;
    logic [DataW-1:0] dividend;
    logic [DivW-1:0]  divisor;
  } rem_op_t;

  typedef struct packed {
    logic [DataW-1:0] remainder;
    logic             div_by_zero;
  } rem_res_t;
endpackage

FILE: sim/iru_checker.sv
`timescale 1ns / 100ps

module iru_checker import iru_pkg::*; import iru_tb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_ready_i,
  input  logic [1:0] req_func_i,
  input  logic [DataW-1:0] req_dividend_i,
  input  logic [DivW-1:0] req_divisor_i,
  input  logic rsp_valid_i,
  input  logic rsp_ready_i,
  input  logic [DataW-1:0] rsp_remainder_i,
  input  logic rsp_div_by_zero_i,
  output int   errors_o,
  output int   pending_o,
  output int   results_o
);
  rem_res_t expected_q[$];

  function automatic logic [63:0] sext(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function automatic rem_res_t trunc_rem(input func_e f, input logic [63:0] v,
                                         input logic [31:0] m);
    rem_res_t r;
    logic [63:0] a;
    logic [63:0] d;
    r.div_by_zero = (m == '0);
    a = v;
    d = sext(m);
    case (f)
      FUNC_S32: a = sext(v[31:0]);
      FUNC_U32: begin
        a = {32'd0, v[31:0]};
        d = {32'd0, m};
      end
      default: ;
    endcase
    if (r.div_by_zero) begin
      r.remainder = a;
    end else if (f == FUNC_S32 || f == FUNC_S64) begin
      r.remainder = abs64(a) % abs64(d);
      if (a[63]) r.remainder = -r.remainder;
    end else begin
      r.remainder = a % d;
    end
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rem_res_t e;
    if (!rst_ni) begin
      errors_o  <= 0;
      results_o <= 0;
      expected_q.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        results_o <= results_o + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word rem=%h dbz=%b", $time, rsp_remainder_i,
                   rsp_div_by_zero_i);
          errors_o <= errors_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.remainder !== rsp_remainder_i || e.div_by_zero !== rsp_div_by_zero_i) begin
            $display("%0t: mismatch expected rem=%h dbz=%b actual rem=%h dbz=%b", $time,
                     e.remainder, e.div_by_zero, rsp_remainder_i, rsp_div_by_zero_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (req_valid_i && req_ready_i)
        expected_q.push_back(trunc_rem(func_e'(req_func_i), req_dividend_i, req_divisor_i));
    end
  end
endmodule

FILE: sim/tb_integer_remainder_unit_top.sv
`timescale 1ns / 100ps

module tb_integer_remainder_unit_top;
  import iru_pkg::*;
  import iru_tb_pkg::*;

  localparam int Latency = 18;
  localparam int NumRandom = 1830;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int errors, pending, results;
  int cycles = 0;
  int sent = 0;
  bit hold_off = 1'b0;
  bit stall_test = 1'b0;
  int dir_count = 0;

  iru_req_if req ();
  iru_rsp_if rsp ();

  integer_remainder_unit_top uut (.clk_i(clk_i), .rst_ni(rst_ni), .req(req), .rsp(rsp));

  iru_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req.valid), .req_ready_i(req.ready), .req_func_i(req.func),
    .req_dividend_i(req.dividend), .req_divisor_i(req.divisor),
    .rsp_valid_i(rsp.valid), .rsp_ready_i(rsp.ready),
    .rsp_remainder_i(rsp.remainder), .rsp_div_by_zero_i(rsp.div_by_zero),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout at cycle %0d", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  rem_op_t dir_ops[$];

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand_dividend();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0: v = 64'h8000_0000_0000_0000;
      1: v = {32'hffff_ffff, 32'h8000_0000};
      2: v = v >> $urandom_range(0, 63);
      3: v = -(v >> $urandom_range(0, 63));
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_divisor();
    logic [31:0] m;
    m = $urandom();
    case ($urandom_range(0, 9))
      0: m = '0;
      1: m = '1;
      2: m = 32'h8000_0000;
      3, 4: m = m >> $urandom_range(0, 31);
      5: m = -(m >> $urandom_range(0, 31));
      default: ;
    endcase
    return m;
  endfunction

  task automatic send_op(input rem_op_t op);
    req.valid    <= 1'b1;
    req.func     <= op.func;
    req.dividend <= op.dividend;
    req.divisor  <= op.divisor;
    do @(posedge clk_i); while (!req.ready);
    sent++;
  endtask

  task automatic idle_req(input int n);
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // receiver: random backpressure, plus one long hold-off on request
  initial begin
    int g;
    rsp.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        rsp.ready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g == 0 || ($urandom_range(0, 3) == 0 && stall_test)) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    rem_op_t op;
    logic [63:0] dvd[4];
    logic [31:0] dvs[5];
    int w;
    req.valid = 1'b0;
    req.func = FUNC_S32;
    req.dividend = '0;
    req.divisor = '0;
    dvd = '{64'h8000_0000_0000_0000, 64'hffff_ffff_8000_0000, 64'hffff_ffff_ffff_ffff,
            64'h7fff_ffff_ffff_ffff};
    dvs = '{32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'd7};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every mode against the extreme divisors and dividends
    for (int f = 0; f < 4; f++) begin
      for (int i = 0; i < 5; i++) begin
        op.func = func_e'(f);
        op.dividend = dvd[(i + f) % 4];
        op.divisor = dvs[i];
        send_op(op);
      end
    end
    op = '{FUNC_S32, 64'h1234_5678_8000_0000, 32'hffff_ffff};
    send_op(op);
    op = '{FUNC_U64, 64'd0, 32'd1};
    send_op(op);
    op = '{FUNC_S64, 64'hdead_beef_0000_0005, 32'hffff_fffd};
    send_op(op);
    dir_count = sent;

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 400) begin
        // long receiver hold-off while words keep coming
        hold_off = 1'b1;
      end
      if (n == 900) begin
        // drain fully before continuing
        req.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      stall_test = (n > 1200);
      w = gap_len();
      idle_req(w);
      op.func = func_e'($urandom_range(0, 3));
      op.dividend = rand_dividend();
      op.divisor = rand_divisor();
      send_op(op);
    end
    req.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    $display("sent %0d words (%0d directed) in all four modes, checked %0d results",
             sent, dir_count, results);
    $display("covered zero divisor, signed minimum over minus one and long output stalls");
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

FILE: integer_remainder_unit_top.f
+incdir+hw/rtl
hw/rtl/iru_pkg.sv
hw/rtl/iru_if.sv
hw/rtl/iru_div_stage.sv
hw/rtl/integer_remainder_unit_top.sv
sim/iru_tb_if.sv
sim/iru_checker.sv
sim/tb_integer_remainder_unit_top.sv
